>>> hw/rtl/bmpp_pkg.sv
// bmpp_pkg: shared types and constants for the 24-bit bmp stream parser
// used by bmpp_hdr, bmpp_out_buf and bmp_rgb24_stream_parser; no dependencies

package bmpp_pkg;

    localparam int DIM_BITS       = 16;
    localparam int HDR_BYTES      = 54;
    localparam int FILE_HDR_BYTES = 14;
    localparam int INFO_HDR_BYTES = 40;
    localparam int OFS_SIZE       = 2;
    localparam int OFS_WIDTH      = 18;
    localparam int OFS_HEIGHT     = 22;
    localparam int CNT_BITS       = 6;
    localparam logic [31:0] DIM_MAX = 32'((64'd1 << DIM_BITS) - 64'd1);
    localparam logic [CNT_BITS-1:0] HDR_LAST = CNT_BITS'(FILE_HDR_BYTES + INFO_HDR_BYTES - 1);
    localparam logic [CNT_BITS-1:0] FILE_HDR_LEN = CNT_BITS'(FILE_HDR_BYTES);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_PIXEL  = 3'd1,
        PH_PAD    = 3'd2,
        PH_DONE   = 3'd3,
        PH_HOLD   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DIMS  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_FILE_HDR   = 3'd1,
        ERR_INFO_HDR   = 3'd2,
        ERR_SIZE       = 3'd3,
        ERR_PIXEL      = 3'd4,
        ERR_PAD        = 3'd5,
        ERR_TOO_LARGE  = 3'd6
    } err_t;

    typedef struct packed {
        logic clear;
        logic capture;
    } hdr_ctl_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic [31:0]         width;
        logic [31:0]         height;
        logic [1:0]          pad;
        logic                size_ok;
        logic                dims_ok;
    } hdr_info_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] width;
        logic [15:0] height;
        err_t        error_code;
        logic        last_pixel;
    } result_t;

endpackage

>>> hw/rtl/bmp_rgb24_stream_parser.sv
// bmp_rgb24_stream_parser: top level of the 24-bit bmp byte stream parser
// depends on bmpp_pkg, bmpp_hdr and bmpp_out_buf
//
// Takes one file byte per transfer at a sustained rate of one transfer per clock.
// A result is registered in the output register, or in its skid stage while the
// output is held; the input only stalls when the output register and its skid
// stage both hold results the downstream side has not yet taken. The file size
// check multiplier is fed from registered header fields and has the whole info
// header to settle, so the 54th header byte is handled like any other byte.

module bmp_rgb24_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [15:0] column,
    output logic [15:0] row,
    output logic [15:0] width,
    output logic [15:0] height,
    output logic [2:0]  error_code,
    output logic        last_pixel
);

    localparam int DB = bmpp_pkg::DIM_BITS;

    bmpp_pkg::phase_t    phase_reg;
    bmpp_pkg::phase_t    phase_next;
    logic [DB-1:0]       column_count_reg;
    logic [DB-1:0]       column_count_next;
    logic [DB-1:0]       row_count_reg;
    logic [DB-1:0]       row_count_next;
    logic [1:0]          channel_index_reg;
    logic [1:0]          channel_index_next;
    logic [1:0]          pad_count_reg;
    logic [1:0]          pad_count_next;
    logic [7:0]          blue_hold_reg;
    logic [7:0]          green_hold_reg;
    logic                blue_load;
    logic                green_load;

    logic                accept;
    logic                take_ok;
    bmpp_pkg::hdr_ctl_t  hdr_ctl;
    bmpp_pkg::hdr_info_t hdr;
    logic                res_valid;
    bmpp_pkg::result_t   res;
    bmpp_pkg::result_t   out_res;
    logic [DB:0]         col_inc;
    logic [31:0]         col_wide;
    logic [31:0]         row_wide;
    bmpp_pkg::err_t      eof_err;

    assign in_ready = take_ok;
    assign accept   = in_valid && take_ok;

    assign hdr_ctl.clear   = accept && action;
    assign hdr_ctl.capture = accept && !action && (phase_reg == bmpp_pkg::PH_HEADER);

    bmpp_hdr u_hdr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hdr_ctl),
        .data_byte (data_byte),
        .info      (hdr)
    );

    assign col_inc  = (DB+1)'(column_count_reg) + 1'b1;
    assign col_wide = 32'(column_count_reg);
    assign row_wide = 32'(row_count_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        channel_index_next = channel_index_reg;
        pad_count_next     = pad_count_reg;
        blue_load          = 1'b0;
        green_load         = 1'b0;
        res_valid          = 1'b0;
        res                = '0;
        eof_err            = bmpp_pkg::ERR_NONE;

        if (accept && action)
        begin
            unique case (phase_reg)
                bmpp_pkg::PH_HEADER:
                    eof_err = (hdr.count < bmpp_pkg::FILE_HDR_LEN) ? bmpp_pkg::ERR_FILE_HDR
                                                                  : bmpp_pkg::ERR_INFO_HDR;
                bmpp_pkg::PH_PIXEL: eof_err = bmpp_pkg::ERR_PIXEL;
                bmpp_pkg::PH_PAD:   eof_err = bmpp_pkg::ERR_PAD;
                default:            eof_err = bmpp_pkg::ERR_NONE;
            endcase
            phase_next         = bmpp_pkg::PH_HEADER;
            column_count_next  = '0;
            row_count_next     = '0;
            channel_index_next = '0;
            pad_count_next     = '0;
            if (eof_err != bmpp_pkg::ERR_NONE)
            begin
                res_valid      = 1'b1;
                res.kind       = bmpp_pkg::KIND_ERROR;
                res.error_code = eof_err;
            end
        end
        else if (accept)
        begin
            unique case (phase_reg)
                bmpp_pkg::PH_HEADER:
                begin
                    if (hdr.count == bmpp_pkg::HDR_LAST)
                    begin
                        res_valid = 1'b1;
                        if (!hdr.size_ok)
                        begin
                            phase_next     = bmpp_pkg::PH_HOLD;
                            res.kind       = bmpp_pkg::KIND_ERROR;
                            res.error_code = bmpp_pkg::ERR_SIZE;
                        end
                        else if (!hdr.dims_ok)
                        begin
                            phase_next     = bmpp_pkg::PH_HOLD;
                            res.kind       = bmpp_pkg::KIND_ERROR;
                            res.error_code = bmpp_pkg::ERR_TOO_LARGE;
                        end
                        else
                        begin
                            column_count_next  = '0;
                            channel_index_next = '0;
                            pad_count_next     = '0;
                            if ((hdr.width == '0) || (hdr.height == '0))
                            begin
                                phase_next = bmpp_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_next     = bmpp_pkg::PH_PIXEL;
                                row_count_next = hdr.height[DB-1:0] - 1'b1;
                            end
                            res.kind   = bmpp_pkg::KIND_DIMS;
                            res.width  = hdr.width[15:0];
                            res.height = hdr.height[15:0];
                        end
                    end
                end
                bmpp_pkg::PH_PIXEL:
                begin
                    if (channel_index_reg == 2'd0)
                    begin
                        blue_load          = 1'b1;
                        channel_index_next = 2'd1;
                    end
                    else if (channel_index_reg == 2'd1)
                    begin
                        green_load         = 1'b1;
                        channel_index_next = 2'd2;
                    end
                    else
                    begin
                        channel_index_next = 2'd0;
                        res_valid          = 1'b1;
                        res.kind           = bmpp_pkg::KIND_PIXEL;
                        res.blue           = blue_hold_reg;
                        res.green          = green_hold_reg;
                        res.red            = data_byte;
                        res.column         = col_wide[15:0];
                        res.row            = row_wide[15:0];
                        res.last_pixel     = (row_count_reg == '0)
                                             && (33'(col_inc) == 33'(hdr.width));
                        column_count_next  = col_inc[DB-1:0];
                        if (33'(col_inc) >= 33'(hdr.width))
                        begin
                            if (hdr.pad != 2'd0)
                            begin
                                phase_next     = bmpp_pkg::PH_PAD;
                                pad_count_next = '0;
                            end
                            else
                            begin
                                column_count_next = '0;
                                pad_count_next    = '0;
                                if (row_count_reg == '0)
                                begin
                                    phase_next = bmpp_pkg::PH_DONE;
                                end
                                else
                                begin
                                    row_count_next = row_count_reg - 1'b1;
                                end
                            end
                        end
                    end
                end
                bmpp_pkg::PH_PAD:
                begin
                    pad_count_next = pad_count_reg + 1'b1;
                    if ((pad_count_reg + 1'b1) >= hdr.pad)
                    begin
                        column_count_next = '0;
                        pad_count_next    = '0;
                        if (row_count_reg == '0)
                        begin
                            phase_next = bmpp_pkg::PH_DONE;
                        end
                        else
                        begin
                            row_count_next = row_count_reg - 1'b1;
                            phase_next     = bmpp_pkg::PH_PIXEL;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= bmpp_pkg::PH_HEADER;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            channel_index_reg <= '0;
            pad_count_reg     <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
            channel_index_reg <= channel_index_next;
            pad_count_reg     <= pad_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blue_load)
        begin
            blue_hold_reg <= data_byte;
        end
        if (green_load)
        begin
            green_hold_reg <= data_byte;
        end
    end

    bmpp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .take_ok   (take_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind       = out_res.kind;
    assign blue       = out_res.blue;
    assign green      = out_res.green;
    assign red        = out_res.red;
    assign column     = out_res.column;
    assign row        = out_res.row;
    assign width      = out_res.width;
    assign height     = out_res.height;
    assign error_code = out_res.error_code;
    assign last_pixel = out_res.last_pixel;

endmodule

>>> hw/rtl/bmpp_hdr.sv
// bmpp_hdr: header byte counter, field capture and file size check
// depends on bmpp_pkg

module bmpp_hdr
(
    input  logic               clk,
    input  logic               rst_n,
    input  bmpp_pkg::hdr_ctl_t ctl,
    input  logic [7:0]         data_byte,
    output bmpp_pkg::hdr_info_t info
);

    logic [bmpp_pkg::CNT_BITS-1:0] count_reg;
    logic [bmpp_pkg::CNT_BITS-1:0] count_next;
    logic [31:0] filesize_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;
    logic [31:0] stride_reg;
    logic [31:0] product_reg;
    logic [31:0] expect_size;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.capture)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // little-endian field lanes
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (count_reg == bmpp_pkg::CNT_BITS'(bmpp_pkg::OFS_SIZE + k))
                begin
                    filesize_reg[8*k +: 8] <= data_byte;
                end
                if (count_reg == bmpp_pkg::CNT_BITS'(bmpp_pkg::OFS_WIDTH + k))
                begin
                    width_reg[8*k +: 8] <= data_byte;
                end
                if (count_reg == bmpp_pkg::CNT_BITS'(bmpp_pkg::OFS_HEIGHT + k))
                begin
                    height_reg[8*k +: 8] <= data_byte;
                end
            end
        end
    end

    // row stride 3w+pad, where pad equals w mod 4; settles long before the last header byte
    always_ff @(posedge clk)
    begin
        stride_reg  <= (width_reg + width_reg + width_reg) + {30'd0, width_reg[1:0]};
        product_reg <= height_reg * stride_reg;
    end

    assign expect_size  = 32'(bmpp_pkg::HDR_BYTES) + product_reg;

    assign info.count   = count_reg;
    assign info.width   = width_reg;
    assign info.height  = height_reg;
    assign info.pad     = width_reg[1:0];
    assign info.size_ok = (expect_size == filesize_reg);
    assign info.dims_ok = (width_reg <= bmpp_pkg::DIM_MAX) && (height_reg <= bmpp_pkg::DIM_MAX);

endmodule

>>> hw/rtl/bmpp_out_buf.sv
// bmpp_out_buf: result register with a skid stage on the output channel
// depends on bmpp_pkg

module bmpp_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  bmpp_pkg::result_t  res,
    output logic               take_ok,
    output logic               out_valid,
    input  logic               out_ready,
    output bmpp_pkg::result_t  out_res
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic              main_load;
    logic              skid_load;
    bmpp_pkg::result_t main_reg;
    bmpp_pkg::result_t skid_reg;

    assign take_ok   = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_comb
    begin
        main_load       = 1'b0;
        skid_load       = 1'b0;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || out_ready)
        begin
            main_load       = 1'b1;
            main_valid_next = skid_valid_reg || res_valid;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
        begin
            main_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (skid_load)
        begin
            skid_reg <= res;
        end
    end

endmodule
